>>> rtl/core/tms_pkg.sv
// ----------------------------------------------------------------------------
// tms_pkg
// Shared types and constants of the text marquee scroller.
// ----------------------------------------------------------------------------
package tms_pkg;

  localparam int unsigned WindowDef      = 44;
  localparam int unsigned TextDepthDef   = 64;
  localparam int unsigned PauseFramesDef = 10;

  localparam int unsigned ColumnW  = 6;
  localparam int unsigned CharW    = 8;
  localparam int unsigned IndexW   = 6;
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned LengthW  = 7;
  localparam int unsigned StepW    = 9;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [PeriodW-1:0] FramePeriodReset = 16'd400;
  localparam logic [CharW-1:0]   SpaceCode        = 8'd32;

  localparam logic [CfgIdxW-1:0] CfgFramePeriod = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgTextLength  = 1'b1;

  localparam logic FuncTick  = 1'b0;
  localparam logic FuncWrite = 1'b1;

  localparam logic [1:0] PhAppear = 2'd0;
  localparam logic [1:0] PhLeave  = 2'd1;
  localparam logic [1:0] PhPause  = 2'd2;

  typedef struct packed {
    logic              func;
    logic              run;
    logic [IndexW-1:0] text_index;
    logic [CharW-1:0]  text_byte;
  } tms_in_t;

  typedef struct packed {
    logic [ColumnW-1:0] column;
    logic [CharW-1:0]   char_code;
    logic               last_column;
  } tms_out_t;

  typedef struct packed {
    logic [1:0]       phase;
    logic [StepW-1:0] step;
    logic [StepW-1:0] len;
  } tms_start_t;

endpackage

>>> rtl/core/tms_in_if.sv
// ----------------------------------------------------------------------------
// tms_in_if
// Valid/ready channel that carries input items of the marquee.
// ----------------------------------------------------------------------------
interface tms_in_if import tms_pkg::*; ();
  logic    valid;
  logic    ready;
  tms_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/tms_out_if.sv
// ----------------------------------------------------------------------------
// tms_out_if
// Valid/ready channel that carries frame columns of the marquee.
// ----------------------------------------------------------------------------
interface tms_out_if import tms_pkg::*; ();
  logic     valid;
  logic     ready;
  tms_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/tms_ram.sv
// ----------------------------------------------------------------------------
// tms_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module tms_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/tms_frame_gen.sv
// ----------------------------------------------------------------------------
// tms_frame_gen
// Walks the window columns of one frame, reads the text store and emits one
// column transaction per cycle through an output register unless it stalls.
// ----------------------------------------------------------------------------
module tms_frame_gen import tms_pkg::*; #(
  parameter int unsigned Window    = WindowDef,
  parameter int unsigned TextDepth = TextDepthDef,
  localparam int unsigned AddrW = (TextDepth > 1) ? $clog2(TextDepth) : 1,
  localparam int unsigned ColW  = (Window > 1) ? $clog2(Window) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  tms_start_t       start_req_i,
  output logic             busy_o,
  output logic             ram_re_o,
  output logic [AddrW-1:0] ram_raddr_o,
  input  logic [CharW-1:0] ram_rdata_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tms_out_t         out_data_o
);

  tms_start_t req_q;
  logic            iss_active_q, iss_active_d;
  logic [ColW-1:0] col_q, col_d;
  logic            rd_valid_q, rd_valid_d;
  logic [ColW-1:0] rd_col_q;
  logic            rd_text_q;
  logic            out_valid_q, out_valid_d;
  tms_out_t        out_q;

  logic             move;
  logic             iss_fire;
  logic [StepW-1:0] col_x;
  logic [StepW-1:0] leave_k;
  logic [StepW-1:0] lead;
  logic [StepW-1:0] shown;
  logic [StepW-1:0] diff;
  logic             use_text;
  logic [StepW-1:0] text_k;

  assign move     = rd_valid_q && (!out_valid_q || out_ready_i);
  assign iss_fire = iss_active_q && (!rd_valid_q || move);

  assign col_x   = StepW'(col_q);
  assign leave_k = col_x + req_q.step;
  assign lead    = StepW'(Window) - req_q.step;
  assign shown   = (req_q.step < req_q.len) ? req_q.step : req_q.len;
  assign diff    = col_x - lead;

  always_comb begin
    use_text = 1'b0;
    text_k   = leave_k;
    case (req_q.phase)
      PhLeave: begin
        use_text = leave_k < req_q.len;
        text_k   = leave_k;
      end
      PhAppear: begin
        use_text = (col_x >= lead) && (diff < shown);
        text_k   = diff;
      end
      default: begin
        use_text = 1'b0;
        text_k   = leave_k;
      end
    endcase
  end

  assign ram_re_o    = iss_fire && use_text;
  assign ram_raddr_o = AddrW'(text_k);

  always_comb begin
    iss_active_d = iss_active_q;
    col_d        = col_q;
    if (start_i) begin
      iss_active_d = 1'b1;
      col_d        = '0;
    end else if (iss_fire) begin
      if (col_q == ColW'(Window - 1)) begin
        iss_active_d = 1'b0;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
    rd_valid_d  = iss_fire ? 1'b1 : (move ? 1'b0 : rd_valid_q);
    out_valid_d = move ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_active_q <= 1'b0;
      col_q        <= '0;
      rd_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      iss_active_q <= iss_active_d;
      col_q        <= col_d;
      rd_valid_q   <= rd_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      req_q <= start_req_i;
    end
    if (iss_fire) begin
      rd_col_q  <= col_q;
      rd_text_q <= use_text;
    end
    if (move) begin
      out_q.column      <= ColumnW'(rd_col_q);
      out_q.char_code   <= rd_text_q ? ram_rdata_i : SpaceCode;
      out_q.last_column <= rd_col_q == ColW'(Window - 1);
    end
  end

  assign busy_o      = iss_active_q || rd_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_o)
    else $error("Frame started while the previous frame was still being read.");

  a_start_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> iss_active_q && (col_q == '0))
    else $error("Frame start did not begin at the leftmost column.");

  a_read_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q && !move |=> rd_valid_q && $stable(rd_col_q))
    else $error("Pending read data was disturbed while the output stalled.");

  a_last_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.last_column |-> out_q.column == ColumnW'(Window - 1))
    else $error("Last column flag on a column other than the rightmost.");

endmodule

>>> rtl/core/text_marquee_scroller.sv
// ----------------------------------------------------------------------------
// text_marquee_scroller
// Scrolling text marquee that emits frames of Window character columns.
// ----------------------------------------------------------------------------
// Input items arrive on in_i. A write item stores text_byte at text_index of
// the text store and produces nothing. A tick item counts one millisecond of
// the frame wait; a wait starts only on a tick with run set and then always
// completes. The tick that ends a wait starts a frame of Window column
// transactions on out_o, one per cycle while the receiver takes them; each
// column passes the issue state, the read register and the output register.
// While a frame is read from the text store, in_i is not ready, so an item
// that starts a frame blocks the input until its last column is read. The
// rate is set by the single read port of the text store, one column per
// cycle. The last column may wait in the output register while the next
// item is accepted. When the receiver stalls, the read pipeline holds and
// the input stays blocked until the frame has left the store. Reset clears
// the wait, the phase and the registers (frame_period 400, text_length 0);
// the text store is not cleared and must be written before it is shown. The
// user writes registers through cfg_we_i while idle; no check enforces it.
// ----------------------------------------------------------------------------
module text_marquee_scroller import tms_pkg::*; #(
  parameter int unsigned Window      = WindowDef,
  parameter int unsigned TextDepth   = TextDepthDef,
  parameter int unsigned PauseFrames = PauseFramesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [PeriodW-1:0] cfg_wdata_i,
  tms_in_if.sink             in_i,
  tms_out_if.source          out_o
);

  localparam int unsigned AddrW = (TextDepth > 1) ? $clog2(TextDepth) : 1;

  logic [PeriodW-1:0] frame_period_q, frame_period_d;
  logic [LengthW-1:0] text_length_q, text_length_d;
  logic [PeriodW-1:0] wait_cnt_q, wait_cnt_d;
  logic               waiting_q, waiting_d;
  logic [1:0]         phase_q, phase_d;
  logic [StepW-1:0]   step_q, step_d;

  logic               busy;
  logic               in_fire;
  logic               tick;
  logic               frame_fire;
  logic [PeriodW-1:0] eff_cnt;
  logic [StepW-1:0]   len;
  logic [1:0]         adj_phase;
  logic [StepW-1:0]   adj_step;
  logic [StepW-1:0]   step_n;
  tms_start_t         start_req;
  logic               ram_we;
  logic               ram_re;
  logic [AddrW-1:0]   ram_raddr;
  logic [CharW-1:0]   ram_rdata;

  assign in_i.ready = !busy;
  assign in_fire    = in_i.valid && !busy;
  assign tick       = in_fire && (in_i.payload.func == FuncTick);
  assign ram_we     = in_fire && (in_i.payload.func == FuncWrite) &&
                      (StepW'(in_i.payload.text_index) < StepW'(TextDepth));

  assign len = (StepW'(text_length_q) > StepW'(TextDepth)) ?
               StepW'(TextDepth) : StepW'(text_length_q);

  always_comb begin
    frame_period_d = frame_period_q;
    text_length_d  = text_length_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CfgFramePeriod: frame_period_d = cfg_wdata_i;
        CfgTextLength:  text_length_d  = cfg_wdata_i[LengthW-1:0];
        default: begin
          frame_period_d = frame_period_q;
        end
      endcase
    end
  end

  assign eff_cnt = waiting_q ? wait_cnt_q : frame_period_q;

  always_comb begin
    waiting_d  = waiting_q;
    wait_cnt_d = wait_cnt_q;
    frame_fire = 1'b0;
    if (tick && (waiting_q || in_i.payload.run)) begin
      if (eff_cnt > PeriodW'(1)) begin
        waiting_d  = 1'b1;
        wait_cnt_d = eff_cnt - 1'b1;
      end else begin
        waiting_d  = 1'b0;
        wait_cnt_d = '0;
        frame_fire = 1'b1;
      end
    end
  end

  always_comb begin
    adj_phase = phase_q;
    adj_step  = step_q;
    case (phase_q)
      PhAppear: begin
        if (step_q > StepW'(Window)) begin
          adj_step = StepW'(Window);
        end
      end
      PhLeave: begin
        if (step_q >= len) begin
          adj_phase = PhPause;
          adj_step  = '0;
        end
      end
      PhPause: begin
        adj_phase = PhPause;
      end
      default: begin
        adj_phase = PhAppear;
        adj_step  = '0;
      end
    endcase

    step_n  = adj_step + 1'b1;
    phase_d = adj_phase;
    step_d  = step_n;
    case (adj_phase)
      PhLeave: begin
        if (step_n >= len) begin
          phase_d = PhPause;
          step_d  = '0;
        end
      end
      PhPause: begin
        if (step_n >= StepW'(PauseFrames)) begin
          phase_d = PhAppear;
          step_d  = '0;
        end
      end
      default: begin
        if (step_n > StepW'(Window)) begin
          phase_d = (len == '0) ? PhPause : PhLeave;
          step_d  = '0;
        end
      end
    endcase
  end

  assign start_req.phase = adj_phase;
  assign start_req.step  = adj_step;
  assign start_req.len   = len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_period_q <= FramePeriodReset;
      text_length_q  <= '0;
      wait_cnt_q     <= '0;
      waiting_q      <= 1'b0;
      phase_q        <= PhAppear;
      step_q         <= '0;
    end else begin
      frame_period_q <= frame_period_d;
      text_length_q  <= text_length_d;
      wait_cnt_q     <= wait_cnt_d;
      waiting_q      <= waiting_d;
      if (frame_fire) begin
        phase_q <= phase_d;
        step_q  <= step_d;
      end
    end
  end

  tms_ram #(
    .Width (CharW),
    .Depth (TextDepth)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AddrW'(in_i.payload.text_index)),
    .wdata_i (in_i.payload.text_byte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tms_frame_gen #(
    .Window    (Window),
    .TextDepth (TextDepth)
  ) u_frame_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (frame_fire),
    .start_req_i (start_req),
    .busy_o      (busy),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.payload)
  );

endmodule
